### hw/rtl/cpts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_pkg
// Types and constants shared by the counter/priority task scheduler modules.
// ----------------------------------------------------------------------------
package cpts_pkg;
	localparam int NumTasks = 64;
	localparam int NumWaitQueues = 16;
	localparam int RefillFactor = 10;
	localparam int TaskW = 6;
	localparam int WqW = 4;
	localparam int PriW = 8;
	localparam int CntW = 12;
	localparam int ModeW = 3;
	localparam int ErrW = 2;
	localparam int CmdQDepth = 2;

	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	typedef enum logic [ModeW-1:0] {
		MODE_ADD = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_SLEEP = 3'd2,
		MODE_WAKEUP = 3'd3,
		MODE_SCHEDULE = 3'd4,
		MODE_SET_COUNTER = 3'd5,
		MODE_NOP6 = 3'd6,
		MODE_NOP7 = 3'd7
	} mode_t;

	typedef enum logic [ErrW-1:0] {
		ERR_OK = 2'd0,
		ERR_IDLE_SLEEP = 2'd1,
		ERR_NOT_QUEUED = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_UNLINK,
		ST_PICK_GO,
		ST_PICK,
		ST_REFILL_GO,
		ST_REFILL,
		ST_WAKE,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		mode_t mode;
		logic [TaskW-1:0] task_id;
		logic [WqW-1:0] wq;
		logic [PriW-1:0] pri;
		logic [CntW-1:0] cnt;
	} cmd_t;

	function automatic logic [CntW-1:0] refill(input logic [PriW-1:0] p);
		logic [PriW+4:0] v;
		v = (PriW+5)'(p) * (PriW+5)'(RefillFactor);
		refill = (v > (PriW+5)'(CntMax)) ? CntMax : v[CntW-1:0];
	endfunction
endpackage
`default_nettype wire

### hw/rtl/cpts_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_cmd_queue
// Short command queue that decouples command intake from execution.
// ----------------------------------------------------------------------------
module cpts_cmd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cpts_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output cpts_pkg::cmd_t pop_cmd,
	output logic empty
);
	import cpts_pkg::*;

	cmd_t slot_q [CmdQDepth];
	logic [$clog2(CmdQDepth)-1:0] wr_q, rd_q;
	logic [$clog2(CmdQDepth):0] cnt_q;

	assign full = (cnt_q == ($clog2(CmdQDepth)+1)'(CmdQDepth));
	assign empty = (cnt_q == '0);
	assign pop_cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{$clog2(CmdQDepth){1'b0}}, push} - {{$clog2(CmdQDepth){1'b0}}, pop};
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cpts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_front
// Command intake: takes input beats, classifies the mode and queues them.
// ----------------------------------------------------------------------------
module cpts_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [cpts_pkg::ModeW-1:0] mode,
	input wire logic [cpts_pkg::TaskW-1:0] task_id,
	input wire logic [cpts_pkg::WqW-1:0] wait_queue_id,
	input wire logic [cpts_pkg::PriW-1:0] priority_value,
	input wire logic [cpts_pkg::CntW-1:0] counter_value,
	input wire logic pop,
	output cpts_pkg::cmd_t pop_cmd,
	output logic empty
);
	import cpts_pkg::*;

	logic full;
	cmd_t cmd;

	always_comb begin
		cmd.mode = mode_t'(mode);
		cmd.task_id = task_id;
		cmd.wq = wait_queue_id;
		cmd.pri = priority_value;
		cmd.cnt = counter_value;
		unique case (mode_t'(mode))
			MODE_NOP6, MODE_NOP7: begin
				cmd.task_id = '0;
			end
			default: begin
			end
		endcase
	end

	assign in_stall = full;

	cpts_cmd_queue u_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid && !full),
		.push_cmd(cmd),
		.full(full),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.empty(empty)
	);
endmodule
`default_nettype wire

### hw/rtl/cpts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cpts_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] addr,
	input wire logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### hw/rtl/cpts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_back
// Command execution: owns the task table and walks it for schedule and wakeup.
// ----------------------------------------------------------------------------
module cpts_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_avail,
	input wire cpts_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [cpts_pkg::TaskW-1:0] selected_task,
	output logic need_resched,
	output logic [cpts_pkg::ErrW-1:0] error_code
);
	import cpts_pkg::*;

	// The run queue is kept as head and tail registers plus next and prev
	// links in RAM. Walks stop at the tail, so the tail's next link is never
	// followed. Wakeup reads the wait-queue entry of every slot, added or not.

	back_state_t st_q, st_d;
	cmd_t cmd_q;
	logic [NumTasks-1:0] inq_q, sleeping_q;
	logic [TaskW-1:0] head_q, tail_q, run_q, cur_q, sel_q;
	logic resched_q, second_q;
	logic [ErrW-1:0] err_q;
	logic [CntW-1:0] best_q;

	logic nx_we, pv_we, cn_we, pr_we, sq_we;
	logic [TaskW-1:0] nx_addr, pv_addr, cn_addr, pr_addr, sq_addr;
	logic [TaskW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
	logic [CntW-1:0] cn_wdata, cn_rdata;
	logic [PriW-1:0] pr_rdata;
	logic [WqW-1:0] sq_rdata;

	logic [TaskW-1:0] t, ul_prev, ul_next, sel_n;
	logic [CntW-1:0] best_n;
	logic add_ok, rm_ok, sl_ok, wake_hit;

	cpts_ram #(.Width(TaskW), .Depth(NumTasks)) u_next (
		.clk(clk),
		.we(nx_we),
		.addr(nx_addr),
		.wdata(nx_wdata),
		.rdata(nx_rdata)
	);

	cpts_ram #(.Width(TaskW), .Depth(NumTasks)) u_prev (
		.clk(clk),
		.we(pv_we),
		.addr(pv_addr),
		.wdata(pv_wdata),
		.rdata(pv_rdata)
	);

	cpts_ram #(.Width(CntW), .Depth(NumTasks)) u_cnt (
		.clk(clk),
		.we(cn_we),
		.addr(cn_addr),
		.wdata(cn_wdata),
		.rdata(cn_rdata)
	);

	cpts_ram #(.Width(PriW), .Depth(NumTasks)) u_pri (
		.clk(clk),
		.we(pr_we),
		.addr(pr_addr),
		.wdata(cmd_q.pri),
		.rdata(pr_rdata)
	);

	cpts_ram #(.Width(WqW), .Depth(NumTasks)) u_sleep_q (
		.clk(clk),
		.we(sq_we),
		.addr(sq_addr),
		.wdata(cmd_q.wq),
		.rdata(sq_rdata)
	);

	assign t = cmd_q.task_id;
	assign add_ok = (t != '0) && !inq_q[t];
	assign rm_ok = inq_q[t];
	assign sl_ok = (t != '0) && inq_q[t] && (32'(cmd_q.wq) < NumWaitQueues);
	assign ul_prev = pv_rdata;
	assign ul_next = (t == tail_q) ? '0 : nx_rdata;
	assign wake_hit = sleeping_q[cur_q] && (sq_rdata == cmd_q.wq);

	always_comb begin
		best_n = best_q;
		sel_n = sel_q;
		if (cn_rdata > best_q) begin
			best_n = cn_rdata;
			sel_n = cur_q;
		end
	end

	always_comb begin
		st_d = st_q;
		cmd_pop = 1'b0;
		nx_we = 1'b0;
		pv_we = 1'b0;
		cn_we = 1'b0;
		pr_we = 1'b0;
		sq_we = 1'b0;
		nx_addr = t;
		pv_addr = t;
		cn_addr = t;
		pr_addr = t;
		sq_addr = t;
		nx_wdata = t;
		pv_wdata = tail_q;
		cn_wdata = cmd_q.cnt;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_avail) begin
					cmd_pop = 1'b1;
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				st_d = ST_DONE;
				unique case (cmd_q.mode)
					MODE_ADD: begin
						if (add_ok) begin
							nx_addr = tail_q;
							nx_we = (tail_q != '0);
							pv_we = 1'b1;
							cn_we = 1'b1;
							pr_we = 1'b1;
						end
					end
					MODE_REMOVE: begin
						if (rm_ok) begin
							st_d = ST_UNLINK;
						end
					end
					MODE_SLEEP: begin
						if (sl_ok) begin
							sq_we = 1'b1;
							st_d = ST_UNLINK;
						end
					end
					MODE_WAKEUP: begin
						sq_addr = '0;
						if (32'(cmd_q.wq) < NumWaitQueues) begin
							st_d = ST_WAKE;
						end
					end
					MODE_SCHEDULE: st_d = ST_PICK_GO;
					MODE_SET_COUNTER: cn_we = 1'b1;
					default: begin
					end
				endcase
			end
			ST_UNLINK: begin
				nx_addr = ul_prev;
				nx_wdata = ul_next;
				nx_we = (ul_prev != '0);
				pv_addr = ul_next;
				pv_wdata = ul_prev;
				pv_we = (ul_next != '0);
				st_d = (cmd_q.mode == MODE_SLEEP && run_q == t) ? ST_PICK_GO : ST_DONE;
			end
			ST_PICK_GO: begin
				nx_addr = head_q;
				cn_addr = head_q;
				st_d = (head_q == '0) ? ST_DONE : ST_PICK;
			end
			ST_PICK: begin
				nx_addr = nx_rdata;
				cn_addr = nx_rdata;
				if (cur_q == tail_q) begin
					st_d = (best_n == '0 && !second_q) ? ST_REFILL_GO : ST_DONE;
				end
			end
			ST_REFILL_GO: begin
				nx_addr = head_q;
				pr_addr = head_q;
				st_d = ST_REFILL;
			end
			ST_REFILL: begin
				nx_addr = nx_rdata;
				pr_addr = nx_rdata;
				cn_addr = cur_q;
				cn_wdata = refill(pr_rdata);
				cn_we = 1'b1;
				if (cur_q == tail_q) begin
					st_d = ST_PICK_GO;
				end
			end
			ST_WAKE: begin
				sq_addr = cur_q + 1'b1;
				if (wake_hit) begin
					nx_addr = tail_q;
					nx_wdata = cur_q;
					nx_we = (tail_q != '0);
					pv_addr = cur_q;
					pv_wdata = tail_q;
					pv_we = 1'b1;
				end
				if (cur_q == TaskW'(NumTasks - 1)) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_stall) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inq_q <= '0;
			sleeping_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			run_q <= '0;
			cur_q <= '0;
			sel_q <= '0;
			resched_q <= 1'b0;
			second_q <= 1'b0;
			err_q <= ERR_OK;
			best_q <= '0;
		end else begin
			unique case (st_q)
				ST_EXEC: begin
					err_q <= ERR_OK;
					cur_q <= '0;
					second_q <= 1'b0;
					unique case (cmd_q.mode)
						MODE_ADD: begin
							if (!add_ok) begin
								err_q <= ERR_NOT_QUEUED;
							end else begin
								sleeping_q[t] <= 1'b0;
								inq_q[t] <= 1'b1;
								tail_q <= t;
								if (tail_q == '0) begin
									head_q <= t;
								end
							end
						end
						MODE_REMOVE: begin
							if (!rm_ok) begin
								err_q <= ERR_NOT_QUEUED;
							end else begin
								inq_q[t] <= 1'b0;
							end
						end
						MODE_SLEEP: begin
							if (t == '0) begin
								err_q <= ERR_IDLE_SLEEP;
							end else if (!sl_ok) begin
								err_q <= ERR_NOT_QUEUED;
							end else begin
								inq_q[t] <= 1'b0;
								sleeping_q[t] <= 1'b1;
								if (run_q == t) begin
									resched_q <= 1'b0;
								end
							end
						end
						MODE_SCHEDULE: resched_q <= 1'b0;
						default: begin
						end
					endcase
				end
				ST_UNLINK: begin
					if (ul_prev == '0) begin
						head_q <= ul_next;
					end
					if (ul_next == '0) begin
						tail_q <= ul_prev;
					end
				end
				ST_PICK_GO: begin
					cur_q <= head_q;
					best_q <= '0;
					sel_q <= '0;
					if (head_q == '0) begin
						run_q <= '0;
					end
				end
				ST_PICK: begin
					best_q <= best_n;
					sel_q <= sel_n;
					cur_q <= nx_rdata;
					if (cur_q == tail_q && !(best_n == '0 && !second_q)) begin
						run_q <= sel_n;
					end
				end
				ST_REFILL_GO: begin
					cur_q <= head_q;
					second_q <= 1'b1;
				end
				ST_REFILL: begin
					cur_q <= nx_rdata;
				end
				ST_WAKE: begin
					if (wake_hit) begin
						sleeping_q[cur_q] <= 1'b0;
						inq_q[cur_q] <= 1'b1;
						tail_q <= cur_q;
						if (tail_q == '0) begin
							head_q <= cur_q;
						end
						resched_q <= 1'b1;
					end
					cur_q <= cur_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = (st_q == ST_DONE);
	assign selected_task = run_q;
	assign need_resched = resched_q;
	assign error_code = err_q;
endmodule
`default_nettype wire

### hw/rtl/counter_priority_task_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Counter/priority task scheduler over a 64-slot task table.
// ----------------------------------------------------------------------------
// Each input beat is one command and yields one result beat. Commands enter
// a two-entry queue and execute one at a time. Add, set counter, rejected
// commands and unknown modes finish directly; remove and sleep first unlink
// the task. Schedule walks the N queued tasks, up to 63, once; when every
// counter is zero, a refill pass and a second pick follow. A sleep of the
// running task is followed by a schedule. Wakeup reads the wait-queue RAM
// once per slot. The run queue is walked through the table RAMs one step
// per cycle.
module counter_priority_task_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [cpts_pkg::ModeW-1:0] mode,
	input wire logic [cpts_pkg::TaskW-1:0] task_id,
	input wire logic [cpts_pkg::WqW-1:0] wait_queue_id,
	input wire logic [cpts_pkg::PriW-1:0] priority_value,
	input wire logic [cpts_pkg::CntW-1:0] counter_value,
	output logic out_valid,
	input wire logic out_stall,
	output logic [cpts_pkg::TaskW-1:0] selected_task,
	output logic need_resched,
	output logic [cpts_pkg::ErrW-1:0] error_code
);
	import cpts_pkg::*;

	logic pop, empty;
	cmd_t qcmd;

	cpts_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.task_id(task_id),
		.wait_queue_id(wait_queue_id),
		.priority_value(priority_value),
		.counter_value(counter_value),
		.pop(pop),
		.pop_cmd(qcmd),
		.empty(empty)
	);

	cpts_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_avail(!empty),
		.cmd(qcmd),
		.cmd_pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.selected_task(selected_task),
		.need_resched(need_resched),
		.error_code(error_code)
	);
endmodule
`default_nettype wire

### hw/rtl/cpts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks for the task scheduler.
// ----------------------------------------------------------------------------
module cpts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [cpts_pkg::TaskW-1:0] selected_task,
	input wire logic need_resched,
	input wire logic [cpts_pkg::ErrW-1:0] error_code
);
	import cpts_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(selected_task)
			&& $stable(error_code) && $stable(need_resched))
		else $error("stalled result changed");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code != 2'd3)
		else $error("bad error code");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("results back to back");

	a_idle_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_IDLE_SLEEP |-> $stable(selected_task))
		else $error("idle sleep changed selection");
endmodule

bind counter_priority_task_scheduler cpts_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.selected_task(selected_task),
	.need_resched(need_resched),
	.error_code(error_code)
);
`default_nettype wire
